// ===== rtl/dfd_pkg.sv =====
// dfd_pkg: shared types and constants of the frame difference RMS unit.
// No dependencies.
`default_nettype none
package dfd_pkg;
    localparam int MAX_VOXELS  = 65536;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_VOLUMES = 1024;

    localparam int SumBits   = 50;
    localparam int ValidBits = 17;
    localparam int TotalBits = 34;
    localparam int MeanBits  = 24;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_RUN,
        t_ST_PAIR,
        t_ST_MEAN,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic pair_start;
        logic mean_start;
        logic show;
    } t_cmd;

    typedef struct packed {
        logic pair_busy;
        logic mean_busy;
        logic item_last;
        logic item_vol_end;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/dvars_frame_difference_rms_unit.sv =====
// dvars_frame_difference_rms_unit: top level, mean RMS frame difference.
// Depends on dfd_pkg, dfd_ctrl, dfd_dp, dfd_ram.
// An ordinary voxel is read from RAM in IDLE, then accumulated in RUN.
// A volume end adds a restoring divide and a bit-by-bit root for the pair.
// Series end adds the mean divide, then the result is held until taken.
// Reset (synchronous, active low) clears counters and sums; RAM is not cleared.
`default_nettype none
module dvars_frame_difference_rms_unit import dfd_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [16:0]               i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_voxel_value,
    input  wire logic                      i_in_mask,
    input  wire logic                      i_last_of_series,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [MeanBits-1:0]            o_mean_dvars,
    output logic [9:0]                     o_pair_count,
    output logic                           o_valid_res
);
    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: one transfer at a time
    dfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_ready(i_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_ready    (o_ready),
        .o_out_valid(o_valid)
    );

    dfd_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_value   (i_voxel_value),
        .i_mask    (i_in_mask),
        .i_last    (i_last_of_series),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_mean    (o_mean_dvars),
        .o_pairs   (o_pair_count),
        .o_vres    (o_valid_res)
    );
endmodule
`default_nettype wire

// ===== rtl/dfd_ram.sv =====
// dfd_ram: generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module dfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/dfd_ctrl.sv =====
// dfd_ctrl: sequencer of the frame difference RMS unit.
// Depends on dfd_pkg.
`default_nettype none
module dfd_ctrl import dfd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd,
    output logic      o_ready,
    output logic      o_out_valid
);
    t_state r_state, n_state;
    logic   r_last;     // series end flag of the transfer being closed

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == t_ST_RUN) r_last <= i_stat.item_last;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_ST_IDLE: begin
                if (i_valid) n_state = t_ST_RUN;
            end
            t_ST_RUN: begin
                // item read issued last cycle; ram data now valid
                if (i_stat.item_vol_end) n_state = t_ST_PAIR;
                else if (i_stat.item_last) n_state = t_ST_MEAN;
                else n_state = t_ST_IDLE;
            end
            t_ST_PAIR: begin
                if (!i_stat.pair_busy) begin
                    n_state = r_last ? t_ST_MEAN : t_ST_IDLE;
                end
            end
            t_ST_MEAN: begin
                if (!i_stat.mean_busy) n_state = t_ST_OUT;
            end
            t_ST_OUT: begin
                if (i_out_ready) n_state = t_ST_IDLE;
            end
            default: n_state = t_ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            t_ST_IDLE: o_ready = 1'b0;
            t_ST_RUN: begin
                o_cmd.take = 1'b1;
                o_ready = 1'b1;
                o_cmd.pair_start = i_stat.item_vol_end;
                o_cmd.mean_start = i_stat.item_last & ~i_stat.item_vol_end;
            end
            t_ST_PAIR: o_cmd.mean_start = ~i_stat.pair_busy & r_last;
            t_ST_MEAN: o_cmd.show = 1'b0;
            t_ST_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.show = i_out_ready;
            end
            default: o_ready = 1'b0;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_take_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |-> o_ready) else $error("take without ready");
    a_no_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_ready) else $error("accept while result pending");
    a_run_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_ST_RUN) |=> (r_state != t_ST_RUN))
        else $error("run repeated");
`endif
endmodule
`default_nettype wire

// ===== rtl/dfd_dp.sv =====
// dfd_dp: datapath: previous volume RAM, accumulators, iterative divide/root.
// Depends on dfd_pkg, dfd_ram.
`default_nettype none
module dfd_dp import dfd_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [16:0]               i_cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0] i_value,
    input  wire logic                      i_mask,
    input  wire logic                      i_last,
    input  wire t_cmd                      i_cmd,
    output t_stat                          o_stat,
    output logic [MeanBits-1:0]            o_mean,
    output logic [9:0]                     o_pairs,
    output logic                           o_vres
);
    localparam int IdxBits = $clog2(MAX_VOXELS);
    localparam int CntBits = $clog2(MAX_VOXELS + 1);
    localparam int PcBits  = $clog2(MAX_VOLUMES);
    localparam int DBits   = SAMPLE_BITS + 1;

    logic [16:0]        r_cfg;
    logic [CntBits-1:0] w_count;
    logic [CntBits:0]   r_idx;
    logic               r_havep;
    logic [SumBits-1:0] r_sum;
    logic [ValidBits-1:0] r_vcnt;
    logic [TotalBits-1:0] r_total;
    logic [PcBits-1:0]  r_pairs;
    logic [SAMPLE_BITS-1:0] w_prev;
    logic               w_vol_end, w_inrange;

    always_comb begin
        if (r_cfg == '0) w_count = CntBits'(1);
        else if ({15'd0, r_cfg} > 32'(MAX_VOXELS)) w_count = CntBits'(MAX_VOXELS);
        else w_count = CntBits'(r_cfg);
    end
    assign w_inrange = ({{(32-CntBits-1){1'b0}}, r_idx} < 32'(MAX_VOXELS));
    assign w_vol_end = ((r_idx + 1'b1) >= {1'b0, w_count});

    dfd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_VOXELS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.take & w_inrange),
        .i_addr (r_idx[IdxBits-1:0]),
        .i_wdata(i_value),
        .o_rdata(w_prev)
    );

    // squared difference
    logic signed [DBits-1:0] w_d;
    logic [DBits-1:0] w_ad;
    logic [2*DBits-1:0] w_sq;
    logic [SumBits:0] w_sumx;
    assign w_d  = DBits'(i_value) - DBits'($signed(w_prev));
    assign w_ad = w_d[DBits-1] ? DBits'(-w_d) : DBits'(w_d);
    assign w_sq = w_ad * w_ad;
    assign w_sumx = {1'b0, r_sum} + (SumBits+1)'(w_sq);

    // pair root: restoring divide (sum<<16)/valid, then bit root
    logic [SumBits+15:0] r_num;
    logic [ValidBits-1:0] r_div;
    logic [SumBits+16:0] r_rem;
    logic [6:0]          r_dstep;
    logic                r_dbusy, r_rbusy;
    logic [SumBits+15:0] r_quo;
    logic [65:0]         r_rx;
    logic [33:0]         r_rres;
    logic [5:0]          r_rstep;
    logic [SumBits+16:0] w_rsh;
    logic [67:0]         w_rtry;
    logic [33:0]         w_rnew;
    logic [MeanBits-1:0] w_rms;
    logic [TotalBits:0]  w_tot;
    assign w_rsh = {r_rem[SumBits+15:0], r_num[SumBits+15]};
    // trial: remainder with next two radicand bits, minus 4*root+1
    assign w_rtry = {r_rx, r_quo[47:46]} - {32'd0, r_rres, 2'b01};
    assign w_rnew = {r_rres[32:0], ~w_rtry[67]};

    // mean divide total/pairs
    logic [TotalBits-1:0] r_mq;
    logic [PcBits:0]      r_mr;
    logic [5:0]           r_mstep;
    logic                 r_mbusy;
    logic [PcBits+1:0]    w_msh;
    assign w_msh = {r_mr, r_mq[TotalBits-1]};

    // root value added to the total: saturated, or the root with its last bit
    always_comb begin
        if (r_quo[SumBits+15:48] != 0) w_rms = MeanBits'(2**MeanBits-1);
        else if (w_rnew > 34'(2**MeanBits-1)) w_rms = MeanBits'(2**MeanBits-1);
        else w_rms = MeanBits'(w_rnew);
    end
    assign w_tot = {1'b0, r_total} + (TotalBits+1)'(w_rms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 17'h10000;
            r_idx <= '0; r_havep <= 1'b0; r_sum <= '0; r_vcnt <= '0;
            r_total <= '0; r_pairs <= '0;
            r_dbusy <= 1'b0; r_rbusy <= 1'b0; r_mbusy <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (i_cmd.take) begin
                if (w_inrange && r_havep && i_mask) begin
                    r_sum <= w_sumx[SumBits] ? {SumBits{1'b1}} : w_sumx[SumBits-1:0];
                    if (r_vcnt != {ValidBits{1'b1}}) r_vcnt <= r_vcnt + 1'b1;
                end
                r_idx <= w_vol_end ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.pair_start) begin
                r_havep <= 1'b1;
                r_sum <= '0; r_vcnt <= '0;
                if (r_havep && (r_vcnt != 0 || (w_inrange && r_havep && i_mask))
                    && r_pairs < PcBits'(MAX_VOLUMES-1)) begin
                    r_dbusy <= 1'b1;
                    r_num <= {(w_inrange && i_mask)
                        ? (w_sumx[SumBits] ? {SumBits{1'b1}} : w_sumx[SumBits-1:0])
                        : r_sum, 16'd0};
                    r_div <= (w_inrange && i_mask && r_vcnt != {ValidBits{1'b1}})
                        ? r_vcnt + 1'b1 : r_vcnt;
                    r_rem <= '0; r_dstep <= '0;
                end
            end
            if (r_dbusy) begin
                if (w_rsh >= (SumBits+17)'(r_div)) begin
                    r_rem <= w_rsh - (SumBits+17)'(r_div);
                    r_quo <= {r_quo[SumBits+14:0], 1'b1};
                end else begin
                    r_rem <= w_rsh;
                    r_quo <= {r_quo[SumBits+14:0], 1'b0};
                end
                r_num <= {r_num[SumBits+14:0], 1'b0};
                r_dstep <= r_dstep + 1'b1;
                if (r_dstep == 7'(SumBits+15)) begin
                    r_dbusy <= 1'b0; r_rbusy <= 1'b1;
                    r_rres <= '0; r_rx <= '0; r_rstep <= '0;
                end
            end
            if (r_rbusy) begin
                // quotient >= 2^48 means q >= 2^32: saturate
                if (r_quo[SumBits+15:48] != 0) begin
                    r_rres <= 34'(2**MeanBits-1);
                    r_rbusy <= 1'b0;
                    r_total <= w_tot[TotalBits] ? {TotalBits{1'b1}} : w_tot[TotalBits-1:0];
                    r_pairs <= r_pairs + 1'b1;
                end else begin
                    if (!w_rtry[67]) begin
                        r_rx <= w_rtry[65:0];
                    end else begin
                        r_rx <= {r_rx[63:0], r_quo[47:46]};
                    end
                    r_rres <= w_rnew;
                    // upper bits stay put; low 48 bits feed the root two at a time
                    r_quo <= {r_quo[SumBits+15:48], r_quo[45:0], 2'b00};
                    r_rstep <= r_rstep + 1'b1;
                    if (r_rstep == 6'd23) begin
                        r_rbusy <= 1'b0;
                        r_total <= w_tot[TotalBits] ? {TotalBits{1'b1}} : w_tot[TotalBits-1:0];
                        r_pairs <= r_pairs + 1'b1;
                    end
                end
            end
            if (i_cmd.mean_start) begin
                r_mbusy <= 1'b1; r_mq <= r_total; r_mr <= '0; r_mstep <= '0;
            end
            if (r_mbusy) begin
                if (w_msh >= {1'b0, r_pairs}) begin
                    r_mr <= (PcBits+1)'(w_msh - {1'b0, r_pairs});
                    r_mq <= {r_mq[TotalBits-2:0], 1'b1};
                end else begin
                    r_mr <= w_msh[PcBits:0];
                    r_mq <= {r_mq[TotalBits-2:0], 1'b0};
                end
                r_mstep <= r_mstep + 1'b1;
                if (r_mstep == 6'(TotalBits-1)) r_mbusy <= 1'b0;
            end
            if (i_cmd.show) begin
                r_idx <= '0; r_havep <= 1'b0; r_sum <= '0; r_vcnt <= '0;
                r_total <= '0; r_pairs <= '0;
            end
        end
    end

    assign o_stat.pair_busy    = r_dbusy | r_rbusy | i_cmd.pair_start;
    assign o_stat.mean_busy    = r_mbusy | i_cmd.mean_start;
    assign o_stat.item_last    = i_last;
    assign o_stat.item_vol_end = w_vol_end;
    assign o_vres  = (r_pairs != 0);
    assign o_pairs = o_vres ? 10'(r_pairs) : 10'd0;
    assign o_mean  = !o_vres ? '0 :
        ((r_mq > TotalBits'(2**MeanBits-1)) ? MeanBits'(2**MeanBits-1) : MeanBits'(r_mq));

`ifndef NO_ASSERTIONS
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_dbusy && r_rbusy)) else $error("divide and root overlap");
    a_mean_after_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mbusy |-> !(r_dbusy || r_rbusy)) else $error("mean while pair busy");
    a_pairs_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pairs <= PcBits'(MAX_VOLUMES-1)) else $error("pair count overflow");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench of dvars_frame_difference_rms_unit.
// Depends on dfd_pkg and the unit RTL; a scoreboard class predicts each result.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import dfd_pkg::*;

    // Scoreboard: copy of the series state, queue of pending series results.
    class dvars_scoreboard;
        logic signed [15:0] prev_vol [int];
        int unsigned        vox_idx;
        bit                 have_prev;
        logic [49:0]        sum_sq;
        logic [16:0]        valid_vox;
        logic [33:0]        total;
        int unsigned        pairs;
        int unsigned        vox_count;
        logic [23:0]        exp_mean [$];
        logic [9:0]         exp_pairs [$];
        logic               exp_vres [$];
        int                 errors;

        function new();
            vox_count = 65536;
            clear();
            errors = 0;
        endfunction

        function void clear();
            vox_idx = 0; have_prev = 0; sum_sq = 0; valid_vox = 0;
            total = 0; pairs = 0;
        endfunction

        function void set_count(logic [16:0] v);
            vox_count = v;
        endfunction

        function void add_result(logic [23:0] m, logic [9:0] p, logic vr);
            exp_mean.insert(exp_mean.size(), m);
            exp_pairs.insert(exp_pairs.size(), p);
            exp_vres.insert(exp_vres.size(), vr);
        endfunction

        function longint unsigned isqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned pair_rms(longint unsigned s, longint unsigned n);
            longint unsigned q, r, rt;
            q = s / n;
            r = s % n;
            if (q >= (64'd1 << 32)) return 64'hFFFFFF;
            rt = isqrt((q << 16) + ((r << 16) / n));
            return (rt > 64'hFFFFFF) ? 64'hFFFFFF : rt;
        endfunction

        function int pending();
            return exp_mean.size();
        endfunction

        // note one accepted voxel transfer
        function void note_voxel(logic signed [15:0] v, bit m, bit last);
            int unsigned cnt;
            longint signed d;
            longint unsigned ad, sq, rms, mn;
            cnt = (vox_count == 0) ? 1 : (vox_count > 65536 ? 65536 : vox_count);
            if (vox_idx < 65536) begin
                if (have_prev && m) begin
                    d = longint'(v) - longint'(prev_vol.exists(vox_idx) ?
                                                prev_vol[vox_idx] : 16'sd0);
                    ad = (d < 0) ? -d : d;
                    sq = ad * ad;
                    if (sq > (64'd1 << 50) - 1 - sum_sq) sum_sq = '1;
                    else sum_sq = 50'(sum_sq + sq);
                    if (valid_vox != '1) valid_vox++;
                end
                prev_vol[vox_idx] = v;
            end
            if (vox_idx + 1 >= cnt) begin
                if (have_prev && valid_vox > 0 && pairs < 1023) begin
                    rms = pair_rms(sum_sq, valid_vox);
                    if (rms > (64'd1 << 34) - 1 - total) total = '1;
                    else total = 34'(total + rms);
                    pairs++;
                end
                sum_sq = 0; valid_vox = 0; have_prev = 1; vox_idx = 0;
            end else begin
                vox_idx++;
            end
            if (!last) return;
            if (pairs == 0) begin
                add_result(24'd0, 10'd0, 1'b0);
            end else begin
                mn = total / pairs;
                add_result(mn > 64'hFFFFFF ? 24'hFFFFFF : mn[23:0], pairs[9:0], 1'b1);
            end
            clear();
        endfunction

        task automatic report(string what, longint got, longint want);
            $display("mismatch %s: got %0d want %0d", what, got, want);
            errors++;
        endtask

        // check one result transfer against the oldest expectation
        task automatic check_result(logic [23:0] m, logic [9:0] p, logic vr);
            logic [23:0] em;
            logic [9:0]  ep;
            logic        ev;
            if (exp_mean.size() == 0) begin
                report("unexpected result", m, -1);
                return;
            end
            em = exp_mean.pop_front(); ep = exp_pairs.pop_front();
            ev = exp_vres.pop_front();
            if (m !== em) report("mean_dvars", m, em);
            if (p !== ep) report("pair_count", p, ep);
            if (vr !== ev) report("valid_res", vr, ev);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [16:0] cfg_data = 0;
    logic        in_valid = 0;
    wire         in_ready;
    logic signed [15:0] vox = 0;
    logic        mask = 0;
    logic        last = 0;
    wire         out_valid;
    logic        out_ready = 0;
    wire [MeanBits-1:0] mean_out;
    wire [9:0]   pairs_out;
    wire         vres_out;

    dvars_scoreboard sb;
    bit          quiet;       // stretch with no idling on either side
    int unsigned vol_size;    // voxels per volume in the current setting
    bit          mask_map [int];
    int          sent;        // input transfers issued so far

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    dvars_frame_difference_rms_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_voxel_value(vox), .i_in_mask(mask), .i_last_of_series(last),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_mean_dvars(mean_out), .o_pair_count(pairs_out), .o_valid_res(vres_out)
    );

    // Monitor: every transfer is sampled at the rising edge.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) sb.note_voxel(vox, mask, last);
        if (rst_n && out_valid && out_ready) sb.check_result(mean_out, pairs_out, vres_out);
    end

    // Result side: ready dropped about 11% of cycles, changed at falling edge.
    always @(negedge clk) out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);

    // Drive one voxel transfer; optional idle before it. Valid stays high
    // after the transfer so the next item can follow at once.
    task automatic send_voxel(logic signed [15:0] v, bit m, bit l);
        if (!quiet) begin
            while ($urandom_range(99) < 11) begin
                in_valid <= 0;
                @(negedge clk);
            end
        end
        in_valid <= 1; vox <= v; mask <= m; last <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Wait until all results are in, then a margin for a volume end in flight.
    task automatic drain();
        in_valid <= 0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic set_voxel_count(logic [16:0] v);
        drain();
        cfg_we <= 1; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.set_count(v);
        vol_size = (v == 0) ? 1 : v;
        mask_map.delete();
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(15) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    // One series of whole volumes, optionally ended mid volume.
    task automatic send_series(int vols, bit partial);
        int unsigned n, k;
        bit m;
        n = vols * vol_size;
        if (partial && vol_size > 1) n = n + $urandom_range(vol_size - 1, 1);
        for (k = 0; k < n; k++) begin
            if (!mask_map.exists(k % vol_size)) mask_map[k % vol_size] = ($urandom_range(9) != 0);
            m = mask_map[k % vol_size];
            if ($urandom_range(49) == 0) m = !m;
            send_voxel(rand_sample(), m, k == n - 1);
        end
        sent += n;
    endtask

    initial begin
        sb = new();
        quiet = 0;
        sent = 0;
        vol_size = 65536;
        repeat (6) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: smallest volume, extreme swings, no-pair series, masked-out pair.
        set_voxel_count(1);
        send_voxel(16'sh7FFF, 1, 1);                 // one volume only
        send_voxel(16'sh7FFF, 1, 0);
        send_voxel(16'sh8000, 1, 1);                 // largest difference
        send_voxel(16'sh0000, 0, 0);
        send_voxel(16'sh1234, 0, 1);                 // no valid voxels
        set_voxel_count(0);                          // zero acts as one
        send_voxel(16'sh0005, 1, 0);
        send_voxel(-16'sd5, 1, 1);
        sent += 7;
        set_voxel_count(3);
        send_series(3, 1);                           // partial last volume dropped
        send_series(4, 0);
        set_voxel_count(17'h1FFFF);                  // above max clamps to max
        set_voxel_count(4);
        send_series(2, 0);

        while (sent < 1550) begin
            if ($urandom_range(9) == 0) begin
                set_voxel_count(17'($urandom_range(12, 1)));
            end
            quiet = (sent > 600 && sent < 850);
            send_series($urandom_range(5), $urandom_range(3) == 0);
            if ($urandom_range(19) == 0) drain();    // sender holds until idle
        end

        // Largest count: a one-voxel series that ends before any pair is formed.
        set_voxel_count(17'h10000);
        send_voxel(16'sh0001, 1, 1);
        drain();
        if (sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire
